### design/xesf_pkg.sv
// Package for the XML element span finder.
// Holds the shared constants, register codes, configuration and result types.
// Used by every module in the design folder; depends on nothing.
package xesf_pkg;

	// Sizes of the name compare, the lookahead window and the byte offsets.
	localparam int MAX_NAME     = 8;
	localparam int WIN          = MAX_NAME + 2;
	localparam int OFFSET_BITS  = 32;
	localparam int NAME_BITS    = 8 * MAX_NAME;
	localparam int LEN_BITS     = 4;
	localparam int WIN_IDX_BITS = $clog2(WIN + 1);
	localparam int FLUSH_BITS   = $clog2(WIN + 1);
	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DATA_BITS = 64;

	// Configuration register indexes.
	localparam logic [CFG_IDX_BITS-1:0] REG_ELEMENT_NAME = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_NAME_LENGTH  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_INCLUDE_TAG  = 2'd2;

	// Characters that the scanner looks for.
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;

	// Configuration as seen by the scanner.
	typedef struct packed {
		logic [NAME_BITS-1:0] element_name;
		logic [LEN_BITS-1:0]  name_length;
		logic                 include_tag;
	} cfg_t;

	// One result item.
	typedef struct packed {
		logic                   span_valid;
		logic [OFFSET_BITS-1:0] span_start;
		logic [OFFSET_BITS-1:0] span_end;
		logic                   text_done;
		logic                   none_found;
	} result_t;

	// Window bytes plus the incoming byte; entry 0 is the byte under test.
	typedef logic [WIN:0][7:0] view_t;

	// ASCII lower-case fold.
	function automatic logic [7:0] to_lower(input logic [7:0] c);
		to_lower = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
	endfunction

	// ASCII letter or digit.
	function automatic logic is_alnum(input logic [7:0] c);
		is_alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A);
	endfunction

endpackage

### design/xesf_scan.sv
// Scanner core: lookahead window, tag/comment/quote tracking and span capture.
// One byte is examined per step; a step yields at most one span result.
// Depends on xesf_pkg.
module xesf_scan (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  logic                    clear,
	input  logic [7:0]              incoming,
	input  xesf_pkg::cfg_t          cfg,
	output logic                    emit,
	output xesf_pkg::result_t       result,
	output logic                    any_found
);
	import xesf_pkg::*;

	logic [WIN-1:0][7:0]    window_q;
	logic                   seeking_close_q;
	logic                   in_comment_q;
	logic                   in_tag_q;
	logic                   in_quote_q;
	logic                   tag_matched_q;
	logic [7:0]             quote_byte_q;
	logic [1:0]             skip_count_q;
	logic [OFFSET_BITS-1:0] position_q;
	logic [OFFSET_BITS-1:0] outer_begin_q;
	logic [OFFSET_BITS-1:0] inner_begin_q;
	logic [OFFSET_BITS-1:0] inner_finish_q;
	logic                   any_found_q;

	logic                   seeking_close_d;
	logic                   in_comment_d;
	logic                   in_tag_d;
	logic                   in_quote_d;
	logic                   tag_matched_d;
	logic [7:0]             quote_byte_d;
	logic [1:0]             skip_count_d;
	logic [OFFSET_BITS-1:0] outer_begin_d;
	logic [OFFSET_BITS-1:0] inner_begin_d;
	logic [OFFSET_BITS-1:0] inner_finish_d;
	logic                   any_found_d;
	view_t                  v;

	// Tests whether the configured name, led by a slash when seeking the
	// closing tag, follows the '<' in entry 0 and is not run on by a letter
	// or digit.
	function automatic logic name_follows(input view_t w, input logic seek,
		input logic [NAME_BITS-1:0] name, input logic [LEN_BITS-1:0] nlen);
		logic [LEN_BITS-1:0]     len;
		logic [WIN_IDX_BITS-1:0] base;
		logic                    ok;
		logic                    live;
		logic [7:0]              a;
		logic [7:0]              b;
		len  = (nlen > LEN_BITS'(MAX_NAME)) ? LEN_BITS'(MAX_NAME) : nlen;
		base = seek ? WIN_IDX_BITS'(2) : WIN_IDX_BITS'(1);
		ok   = !seek || (w[1] == CH_SLASH);
		live = 1'b1;
		for (int i = 0; i < MAX_NAME; i++) begin
			a = to_lower(w[base + WIN_IDX_BITS'(i)]);
			b = to_lower(name[8*i +: 8]);
			if ((LEN_BITS'(i) < len) && live) begin
				if (a != b) begin
					ok   = 1'b0;
					live = 1'b0;
				end else if (a == CH_NUL) begin
					live = 1'b0;
				end
			end
		end
		name_follows = ok && !is_alnum(w[base + WIN_IDX_BITS'(len)]);
	endfunction

	assign v = {incoming, window_q};

	// Examine the oldest byte and work out the next scan state.
	always_comb begin
		logic [OFFSET_BITS-1:0] off;
		logic [OFFSET_BITS-1:0] after;
		logic [7:0]             c;
		off   = position_q - OFFSET_BITS'(WIN);
		after = off + OFFSET_BITS'(1);
		c     = v[0];

		seeking_close_d = seeking_close_q;
		in_comment_d    = in_comment_q;
		in_tag_d        = in_tag_q;
		in_quote_d      = in_quote_q;
		tag_matched_d   = tag_matched_q;
		quote_byte_d    = quote_byte_q;
		skip_count_d    = skip_count_q;
		outer_begin_d   = outer_begin_q;
		inner_begin_d   = inner_begin_q;
		inner_finish_d  = inner_finish_q;
		any_found_d     = any_found_q;
		emit            = 1'b0;
		result          = '0;

		priority if (skip_count_q != 2'd0) begin
			skip_count_d = skip_count_q - 2'd1;
		end else if (in_comment_q) begin
			if (c == CH_DASH && v[1] == CH_DASH && v[2] == CH_GT) begin
				in_comment_d = 1'b0;
				skip_count_d = 2'd2;
			end
		end else if (c == CH_LT && v[1] == CH_BANG && v[2] == CH_DASH &&
			v[3] == CH_DASH) begin
			in_comment_d = 1'b1;
			skip_count_d = 2'd3;
		end else if (!in_tag_q) begin
			if (c == CH_LT) begin
				if (name_follows(v, seeking_close_q, cfg.element_name,
					cfg.name_length)) begin
					tag_matched_d = 1'b1;
					if (seeking_close_q) begin
						inner_finish_d = off;
					end else begin
						outer_begin_d = off;
					end
				end
				in_tag_d = 1'b1;
			end
		end else if (!in_quote_q) begin
			if (c == CH_GT) begin
				if (tag_matched_q) begin
					if (!seeking_close_q) begin
						inner_begin_d   = after;
						seeking_close_d = 1'b1;
					end else begin
						emit              = 1'b1;
						result.span_valid = 1'b1;
						result.span_start = cfg.include_tag ? outer_begin_q : inner_begin_q;
						result.span_end   = cfg.include_tag ? after : inner_finish_q;
						any_found_d       = 1'b1;
						seeking_close_d   = 1'b0;
					end
					in_comment_d  = 1'b0;
					in_tag_d      = 1'b0;
					in_quote_d    = 1'b0;
					tag_matched_d = 1'b0;
					quote_byte_d  = CH_NUL;
				end else begin
					in_tag_d = 1'b0;
				end
			end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
				in_quote_d   = 1'b1;
				quote_byte_d = c;
			end
		end else if (c == quote_byte_q) begin
			in_quote_d = 1'b0;
		end
	end

	// Scan state registers; clear returns them to the start of a text.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q        <= '0;
			seeking_close_q <= 1'b0;
			in_comment_q    <= 1'b0;
			in_tag_q        <= 1'b0;
			in_quote_q      <= 1'b0;
			tag_matched_q   <= 1'b0;
			quote_byte_q    <= '0;
			skip_count_q    <= '0;
			position_q      <= '0;
			outer_begin_q   <= '0;
			inner_begin_q   <= '0;
			inner_finish_q  <= '0;
			any_found_q     <= 1'b0;
		end else if (clear) begin
			window_q        <= '0;
			seeking_close_q <= 1'b0;
			in_comment_q    <= 1'b0;
			in_tag_q        <= 1'b0;
			in_quote_q      <= 1'b0;
			tag_matched_q   <= 1'b0;
			quote_byte_q    <= '0;
			skip_count_q    <= '0;
			position_q      <= '0;
			outer_begin_q   <= '0;
			inner_begin_q   <= '0;
			inner_finish_q  <= '0;
			any_found_q     <= 1'b0;
		end else if (step) begin
			window_q        <= v[WIN:1];
			seeking_close_q <= seeking_close_d;
			in_comment_q    <= in_comment_d;
			in_tag_q        <= in_tag_d;
			in_quote_q      <= in_quote_d;
			tag_matched_q   <= tag_matched_d;
			quote_byte_q    <= quote_byte_d;
			skip_count_q    <= skip_count_d;
			position_q      <= position_q + OFFSET_BITS'(1);
			outer_begin_q   <= outer_begin_d;
			inner_begin_q   <= inner_begin_d;
			inner_finish_q  <= inner_finish_d;
			any_found_q     <= any_found_d;
		end
	end

	assign any_found = any_found_q;

endmodule

### design/xesf_out_fifo.sv
// Two-entry result queue that parts the scanner from the output handshake.
// Room is taken from registered state only, so input stall never waits on
// the output side in the same cycle. Depends on xesf_pkg.
module xesf_out_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  xesf_pkg::result_t push_data,
	output logic              room,
	output logic              out_valid,
	input  logic              out_stall,
	output xesf_pkg::result_t out_data
);
	import xesf_pkg::*;

	localparam int DEPTH = 2;

	result_t    mem_q [DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign room      = (count_q < 2'(DEPTH));
	assign out_valid = (count_q != 2'd0);
	assign out_data  = mem_q[rd_ptr_q];
	assign pop       = out_valid && !out_stall;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### design/xml_element_span_finder.sv
// XML element span finder: one text byte per cycle while the queue has room and no flush runs.
// The closing '>' is examined 10 steps (WIN) after it enters the window; its span result is
// queued in that step and offered from the result queue behind any older results.
// On the final byte the window is flushed with 10 NUL steps and the end-of-text result
// follows; a further byte is held in the input register until the flush is over.
// Asynchronous reset clears scan state and the queue and resets the configuration registers.
module xml_element_span_finder (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [xesf_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [xesf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [7:0]                          text_byte,
	input  logic                                final_byte,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                span_valid,
	output logic [xesf_pkg::OFFSET_BITS-1:0]    span_start,
	output logic [xesf_pkg::OFFSET_BITS-1:0]    span_end,
	output logic                                text_done,
	output logic                                none_found
);
	import xesf_pkg::*;

	cfg_t                  cfg_q;
	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  final_s1;
	logic                  flush_active_q;
	logic [FLUSH_BITS-1:0] flush_cnt_q;

	logic       room;
	logic       accept;
	logic       advance_s1;
	logic       flush_step;
	logic       done_push;
	logic       step;
	logic [7:0] incoming;
	logic       emit;
	logic       any_found;
	logic       push;
	result_t    scan_result;
	result_t    push_data;
	result_t    out_data;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.element_name <= '0;
			cfg_q.name_length  <= LEN_BITS'(1);
			cfg_q.include_tag  <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_ELEMENT_NAME: cfg_q.element_name <= cfg_data[NAME_BITS-1:0];
				REG_NAME_LENGTH:  cfg_q.name_length  <= cfg_data[LEN_BITS-1:0];
				REG_INCLUDE_TAG:  cfg_q.include_tag  <= cfg_data[0];
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

	// Handshake and step control.
	assign advance_s1 = valid_s1 && !flush_active_q && room;
	assign in_stall   = valid_s1 && !advance_s1;
	assign accept     = in_valid && !in_stall;
	assign flush_step = flush_active_q && (flush_cnt_q != FLUSH_BITS'(WIN)) && room;
	assign done_push  = flush_active_q && (flush_cnt_q == FLUSH_BITS'(WIN)) && room;
	assign step       = advance_s1 || flush_step;
	assign incoming   = advance_s1 ? byte_s1 : CH_NUL;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1  <= text_byte;
			final_s1 <= final_byte;
		end
	end

	// Flush sequencer: WIN NUL steps, then the end-of-text result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flush_active_q <= 1'b0;
			flush_cnt_q    <= '0;
		end else if (advance_s1 && final_s1) begin
			flush_active_q <= 1'b1;
			flush_cnt_q    <= '0;
		end else if (done_push) begin
			flush_active_q <= 1'b0;
		end else if (flush_step) begin
			flush_cnt_q <= flush_cnt_q + FLUSH_BITS'(1);
		end
	end

	xesf_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.clear     (done_push),
		.incoming  (incoming),
		.cfg       (cfg_q),
		.emit      (emit),
		.result    (scan_result),
		.any_found (any_found)
	);

	// Pick the span result or the end-of-text result.
	always_comb begin
		push_data = scan_result;
		if (done_push) begin
			push_data            = '0;
			push_data.text_done  = 1'b1;
			push_data.none_found = !any_found;
		end
	end

	assign push = (step && emit) || done_push;

	xesf_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign span_valid = out_data.span_valid;
	assign span_start = out_data.span_start;
	assign span_end   = out_data.span_end;
	assign text_done  = out_data.text_done;
	assign none_found = out_data.none_found;

`ifndef SYNTHESIS
	// A byte waiting behind a flush is held, not examined.
	assert property (@(posedge clk) disable iff (!arst_n)
		flush_active_q && valid_s1 |-> in_stall)
		else $error("input not stalled during flush");

	// A flush starts only after a final byte was examined.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(flush_active_q) |-> $past(advance_s1 && final_s1))
		else $error("flush started without a final byte");

	// The end-of-text result ends the flush.
	assert property (@(posedge clk) disable iff (!arst_n)
		done_push |=> !flush_active_q)
		else $error("flush still active after end-of-text result");

	// No span result is produced while the end-of-text result is queued.
	assert property (@(posedge clk) disable iff (!arst_n)
		done_push |-> !step)
		else $error("scan step collides with end-of-text result");
`endif

endmodule

### tb/sv/xml_element_span_finder_tb.sv
// Self-checking testbench for xml_element_span_finder: streams XML text bytes,
// predicts the element spans and end-of-text items, and checks every output item.
// Depends on xesf_pkg and the xml_element_span_finder module from the design folder.
module xml_element_span_finder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import xesf_pkg::*;

	logic                     clk;
	logic                     arst_n     = 1'b0;
	logic                     cfg_write  = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index  = REG_ELEMENT_NAME;
	logic [CFG_DATA_BITS-1:0] cfg_data   = '0;
	logic                     in_valid   = 1'b0;
	logic                     in_stall;
	logic [7:0]               text_byte  = 8'h00;
	logic                     final_byte = 1'b0;
	logic                     out_valid;
	logic                     out_stall  = 1'b0;
	logic                     span_valid;
	logic [OFFSET_BITS-1:0]   span_start;
	logic [OFFSET_BITS-1:0]   span_end;
	logic                     text_done;
	logic                     none_found;

	xml_element_span_finder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.text_byte  (text_byte),
		.final_byte (final_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.span_valid (span_valid),
		.span_start (span_start),
		.span_end   (span_end),
		.text_done  (text_done),
		.none_found (none_found)
	);

	// 10 ns clock.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Run controls shared by the stimulus and the pacing processes.
	int  faults        = 0;
	int  items_sent    = 0;
	int  hold_request  = 0;
	bit  sender_gaps   = 1'b1;
	bit  reader_stalls = 1'b1;

	// Configuration as the scanner should currently see it.
	logic [NAME_BITS-1:0] cfg_name = '0;
	logic [LEN_BITS-1:0]  cfg_len  = 4'd1;
	logic                 cfg_tag  = 1'b0;

	// Scanner state of the prediction.
	logic [WIN-1:0][7:0]    win_bytes;
	logic                   seek_close;
	logic                   in_cmt;
	logic                   in_tag_q;
	logic                   in_quote_q;
	logic                   tag_hit;
	logic [7:0]             quote_ch;
	int unsigned            skip_n;
	logic [OFFSET_BITS-1:0] pos;
	logic [OFFSET_BITS-1:0] outer_b;
	logic [OFFSET_BITS-1:0] inner_b;
	logic [OFFSET_BITS-1:0] inner_f;
	logic                   found_any;

	// Output items still owed by the block, oldest first.
	result_t due_reports[$];

	// Text being assembled for the next send.
	logic [7:0] text_buf[$];

	// Queue helpers.
	function automatic void add_byte(input logic [7:0] b);
		text_buf.insert(text_buf.size(), b);
	endfunction

	function automatic void add_report(input result_t r);
		due_reports.insert(due_reports.size(), r);
	endfunction

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	function automatic logic [7:0] fold_case(input logic [7:0] ch);
		return (ch >= 8'h41 && ch <= 8'h5A) ? (ch | 8'h20) : ch;
	endfunction

	function automatic bit is_word_char(input logic [7:0] ch);
		logic [7:0] f;
		f = fold_case(ch);
		return (ch >= 8'h30 && ch <= 8'h39) || (f >= 8'h61 && f <= 8'h7A);
	endfunction

	// Name bytes actually compared; lengths above the maximum saturate.
	function automatic int name_span();
		return (cfg_len > MAX_NAME) ? MAX_NAME : int'(cfg_len);
	endfunction

	// Every text starts from a clean scanner.
	function automatic void clear_scan();
		win_bytes  = '0;
		seek_close = 1'b0;
		in_cmt     = 1'b0;
		in_tag_q   = 1'b0;
		in_quote_q = 1'b0;
		tag_hit    = 1'b0;
		quote_ch   = CH_NUL;
		skip_n     = 0;
		pos        = '0;
		outer_b    = '0;
		inner_b    = '0;
		inner_f    = '0;
		found_any  = 1'b0;
	endfunction

	// With v[0] at '<', does the configured name (after '/' when closing) follow?
	function automatic bit name_hits(input view_t v);
		int len;
		int base;
		logic [7:0] a;
		logic [7:0] b;
		len  = name_span();
		base = 1;
		if (seek_close) begin
			if (v[1] != CH_SLASH)
				return 1'b0;
			base = 2;
		end
		for (int i = 0; i < len; i++) begin
			a = fold_case(v[base + i]);
			b = fold_case(cfg_name[8*i +: 8]);
			if (a != b)
				return 1'b0;
			// A NUL in both ends the compare early.
			if (a == CH_NUL)
				break;
		end
		return !is_word_char(v[base + len]);
	endfunction

	// Shift one byte into the window and examine the oldest one.
	task automatic scan_byte(input logic [7:0] incoming);
		view_t                  v;
		logic [OFFSET_BITS-1:0] off;
		logic [7:0]             c;
		result_t                span;
		v   = {incoming, win_bytes};
		off = pos - OFFSET_BITS'(WIN);
		c   = v[0];
		if (skip_n > 0) begin
			skip_n--;
		end else if (in_cmt) begin
			if (c == CH_DASH && v[1] == CH_DASH && v[2] == CH_GT) begin
				in_cmt = 1'b0;
				skip_n = 2;
			end
		end else if (c == CH_LT && v[1] == CH_BANG && v[2] == CH_DASH && v[3] == CH_DASH) begin
			// A comment start wins over tag and quote tracking.
			in_cmt = 1'b1;
			skip_n = 3;
		end else if (!in_tag_q) begin
			if (c == CH_LT) begin
				if (name_hits(v)) begin
					tag_hit = 1'b1;
					if (seek_close)
						inner_f = off;
					else
						outer_b = off;
				end
				in_tag_q = 1'b1;
			end
		end else if (!in_quote_q) begin
			if (c == CH_GT) begin
				if (tag_hit) begin
					if (!seek_close) begin
						inner_b    = off + OFFSET_BITS'(1);
						seek_close = 1'b1;
					end else begin
						span            = '0;
						span.span_valid = 1'b1;
						span.span_start = cfg_tag ? outer_b : inner_b;
						span.span_end   = cfg_tag ? off + OFFSET_BITS'(1) : inner_f;
						add_report(span);
						found_any  = 1'b1;
						seek_close = 1'b0;
					end
					in_cmt     = 1'b0;
					in_tag_q   = 1'b0;
					in_quote_q = 1'b0;
					tag_hit    = 1'b0;
					quote_ch   = CH_NUL;
				end else begin
					in_tag_q = 1'b0;
				end
			end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
				in_quote_q = 1'b1;
				quote_ch   = c;
			end
		end else if (c == quote_ch) begin
			in_quote_q = 1'b0;
		end
		win_bytes = v[WIN:1];
		pos       = pos + OFFSET_BITS'(1);
	endtask

	// One accepted item: scan it, and on the last byte flush and close the text.
	task automatic take_byte(input logic [7:0] b, input logic fin);
		result_t done_item;
		scan_byte(b);
		if (fin) begin
			repeat (WIN) scan_byte(CH_NUL);
			done_item            = '0;
			done_item.text_done  = 1'b1;
			done_item.none_found = !found_any;
			add_report(done_item);
			clear_scan();
		end
	endtask

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	function automatic void check_field(input string field, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			faults++;
		end
	endfunction

	// Compare every accepted output item with the oldest expectation.
	always @(posedge clk) begin : check_outputs
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (due_reports.size() == 0) begin
				$error("output item with nothing expected");
				faults++;
			end else begin
				want = due_reports.pop_front();
				check_field("span_valid", 32'(want.span_valid), 32'(span_valid));
				check_field("span_start", want.span_start, span_start);
				check_field("span_end", want.span_end, span_end);
				check_field("text_done", 32'(want.text_done), 32'(text_done));
				check_field("none_found", 32'(want.none_found), 32'(none_found));
			end
		end
	end

	// Receiver pacing: random stall bursts, or one long hold when requested.
	initial begin : reader_pacing
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				out_stall <= 1'b1;
				repeat (hold_request) @(negedge clk);
				hold_request = 0;
				out_stall <= 1'b0;
			end else if (reader_stalls && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 15)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Driving
	// ------------------------------------------------------------------

	// Offer one item from a falling edge and return on the falling edge after acceptance.
	task automatic send_item(input logic [7:0] b, input logic fin);
		if (sender_gaps && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		in_valid   <= 1'b1;
		text_byte  <= b;
		final_byte <= fin;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		take_byte(b, fin);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_text();
		for (int i = 0; i < text_buf.size(); i++)
			send_item(text_buf[i], i == text_buf.size() - 1);
		text_buf.delete();
	endtask

	// Let the block drain completely before the configuration may change.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (due_reports.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// Write all three registers; unused high data bits of the length and tag writes carry random junk.
	task automatic load_config(input logic [63:0] name, input logic [3:0] len, input logic tag);
		cfg_write <= 1'b1;
		cfg_index <= REG_ELEMENT_NAME;
		cfg_data  <= name;
		@(negedge clk);
		cfg_index <= REG_NAME_LENGTH;
		cfg_data  <= {$urandom, 28'($urandom), len};
		@(negedge clk);
		cfg_index <= REG_INCLUDE_TAG;
		cfg_data  <= {$urandom, 31'($urandom), tag};
		@(negedge clk);
		cfg_write <= 1'b0;
		cfg_name = name;
		cfg_len  = len;
		cfg_tag  = tag;
	endtask

	// ------------------------------------------------------------------
	// Text generation
	// ------------------------------------------------------------------

	task automatic append_str(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	// Configured name with the case of each letter picked at random.
	task automatic append_name();
		logic [7:0] ch;
		for (int i = 0; i < name_span(); i++) begin
			ch = cfg_name[8*i +: 8];
			if (is_word_char(ch) && !(ch >= 8'h30 && ch <= 8'h39) && $urandom_range(0, 1))
				ch = ch ^ 8'h20;
			add_byte(ch);
		end
	endtask

	// Opening tag, bare or with an attribute, a quoted '>' or a comment inside.
	task automatic append_open();
		logic [7:0] q;
		add_byte(CH_LT);
		append_name();
		case ($urandom_range(0, 3))
			0: ;
			1: begin
				q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
				append_str(" k=");
				add_byte(q);
				repeat ($urandom_range(0, 4)) begin
					case ($urandom_range(0, 4))
						0: add_byte(CH_GT);
						1: add_byte(CH_LT);
						2: add_byte((q == CH_DQUOTE) ? CH_SQUOTE : CH_DQUOTE);
						3: add_byte(CH_SLASH);
						default: add_byte(8'h78);
					endcase
				end
				add_byte(q);
			end
			2: append_str(" <!--x>-->");
			default: append_str(" k");
		endcase
		add_byte(CH_GT);
	endtask

	task automatic append_close();
		append_str("</");
		append_name();
		if ($urandom_range(0, 3) == 0)
			append_str(" ");
		add_byte(CH_GT);
	endtask

	// Comment, sometimes hiding a matching tag.
	task automatic append_comment();
		append_str("<!--");
		if ($urandom_range(0, 1)) begin
			add_byte(CH_LT);
			append_name();
			add_byte(CH_GT);
		end
		repeat ($urandom_range(0, 2)) add_byte(8'($urandom_range(8'h61, 8'h7A)));
		append_str("-->");
	endtask

	// The name followed by a digit must not match.
	task automatic append_near_miss();
		add_byte(CH_LT);
		if ($urandom_range(0, 1))
			add_byte(CH_SLASH);
		append_name();
		add_byte(8'($urandom_range(8'h30, 8'h39)));
		add_byte(CH_GT);
	endtask

	task automatic append_content();
		repeat ($urandom_range(0, 3)) begin
			case ($urandom_range(0, 4))
				0: repeat ($urandom_range(1, 4))
					add_byte(8'($urandom_range(8'h61, 8'h7A)));
				1: append_comment();
				2: append_near_miss();
				3: append_str("<b/>");
				default: add_byte(8'($urandom_range(0, 255)));
			endcase
		end
	endtask

	// A short text: mostly well-formed elements, with comments, misses and noise.
	task automatic build_text();
		int pick;
		repeat ($urandom_range(1, 2)) begin
			pick = $urandom_range(0, 9);
			if (pick <= 5) begin
				append_open();
				append_content();
				append_close();
			end else if (pick == 6) begin
				append_comment();
			end else if (pick == 7) begin
				append_near_miss();
			end else if (pick == 8) begin
				repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
			end else begin
				// Element whose closing tag never comes.
				append_open();
				append_content();
			end
		end
	endtask

	// Random texts under one setting until enough items have gone by.
	task automatic run_phase(input logic [63:0] name, input logic [3:0] len, input logic tag,
		input int min_items);
		int first_item;
		wait_idle();
		load_config(name, len, tag);
		first_item = items_sent;
		while (items_sent - first_item < min_items) begin
			build_text();
			send_text();
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Short fixed texts: extreme bytes, case folding, embedded NUL, quoted '>'.
	task automatic test_directed_text();
		load_config(64'hA5A5_A5A5_A5A5_A561, 4'd1, 1'b0);
		// Single 0xFF byte: nothing found.
		add_byte(8'hFF);
		send_text();
		// Upper-case opening tag, NUL content, closing tag on the final byte.
		append_str("<A>");
		add_byte(CH_NUL);
		append_str("</a>");
		send_text();
		wait_idle();
		load_config(64'h61, 4'd1, 1'b1);
		append_str("<a q='>'>x</a>");
		send_text();
	endtask

	// Sweep of name, length and span settings, extremes included.
	task automatic test_name_settings();
		run_phase(64'h6D65_7449, 4'd4, 1'b1, 10);
		run_phase(64'h6867_6665_6463_6261, 4'd8, 1'b0, 10);
		run_phase(64'h4847_4645_4443_4241, 4'd15, 1'b1, 10);
		run_phase(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0, 10);
		run_phase(64'h7A7A, 4'd0, 1'b1, 10);
		run_phase(64'h0, 4'd2, 1'b0, 10);
	endtask

	// Receiver holds off for a long time while spans keep piling up.
	task automatic test_output_backpressure();
		wait_idle();
		load_config(64'h61, 4'd1, 1'b1);
		sender_gaps  = 1'b0;
		hold_request = 300;
		repeat (6) append_str("<a></a>");
		send_text();
		sender_gaps = 1'b1;
	endtask

	// Closing stretch at full rate on both sides.
	task automatic test_steady_stream();
		sender_gaps   = 1'b0;
		reader_stalls = 1'b0;
		run_phase(64'h6D65_7449, 4'd4, 1'b0, 20);
	endtask

	initial begin : stimulus
		int drain;
		clear_scan();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_text();
		test_name_settings();
		test_output_backpressure();
		test_steady_stream();
		in_valid <= 1'b0;
		drain = 0;
		while (due_reports.size() != 0 && drain < 20000) begin
			@(negedge clk);
			drain++;
		end
		repeat (30) @(negedge clk);
		if (due_reports.size() != 0) begin
			$error("%0d expected output items never arrived", due_reports.size());
			faults++;
		end
		if (faults == 0) begin
			$display("xml_element_span_finder_tb: PASS");
		end else begin
			$display("xml_element_span_finder_tb: FAIL");
		end
		$finish;
	end

	// Hard stop in case the block hangs.
	initial begin : watchdog
		#3000000;
		$display("xml_element_span_finder_tb: FAIL");
		$finish;
	end

endmodule

### sim.f
design/xesf_pkg.sv
design/xesf_scan.sv
design/xesf_out_fifo.sv
design/xml_element_span_finder.sv
tb/sv/xml_element_span_finder_tb.sv
